FILE: hdl/nrp_pkg.sv
// shared types, constants and helper functions for the rmc position parser
// no dependencies; imported by every module of the block
package nrp_pkg;

    // sentence shape
    localparam int unsigned MAX_FIELDS  = 13;
    localparam int unsigned FRAC_DIGITS = 5;
    localparam int unsigned INT_DIGITS  = 5;
    localparam int unsigned MIN_FIELDS  = 7;

    // character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SOUTH = 8'h53;
    localparam logic [7:0] CH_WEST  = 8'h57;

    localparam logic [23:0] TAG_RMC = 24'h524D43;

    // field indexes
    localparam logic [3:0] FIELD_TAG     = 4'd0;
    localparam logic [3:0] FIELD_LAT     = 4'd3;
    localparam logic [3:0] FIELD_LAT_DIR = 4'd4;
    localparam logic [3:0] FIELD_LON     = 4'd5;
    localparam logic [3:0] FIELD_LON_DIR = 4'd6;

    // conversion constants: minutes are scaled to 1e-5, then divided by 6
    localparam logic [16:0] MM_SCALE    = 17'd100000;
    localparam logic [19:0] DEG_SCALE   = 20'd1000000;
    localparam logic [20:0] RECIP_3     = 21'd1398101;  // floor(2^22 / 3)
    localparam int unsigned RECIP_SHIFT = 22;

    // request queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;

    // raw coordinate as collected by the front end
    typedef struct packed {
        logic        pt;     // decimal point seen
        logic [9:0]  deg;    // integer digits before the minutes
        logic [3:0]  mm_t;   // tens of whole minutes
        logic [3:0]  mm_o;   // units of whole minutes
        logic [16:0] frac;   // minute fraction in units of 1e-5
    } t_coord;

    // one finished line, handed to the back end
    typedef struct packed {
        logic   ok;
        logic   lat_neg;
        logic   lon_neg;
        t_coord lat;
        t_coord lon;
    } t_job;

    // weight of the fraction digit at position cnt, normalised to five digits
    function automatic logic [16:0] frac_weight(input logic [2:0] cnt);
        logic [16:0] w;
        case (cnt)
            3'd0:    w = 17'd10000;
            3'd1:    w = 17'd1000;
            3'd2:    w = 17'd100;
            3'd3:    w = 17'd10;
            3'd4:    w = 17'd1;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/nrp_front.sv
// front end: takes characters, splits fields, collects coordinate digits
// depends on nrp_pkg; emits one request per finished line into the queue
module nrp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_full,
    output logic          o_push,
    output nrp_pkg::t_job o_job
);
    import nrp_pkg::*;

    logic        r_line, n_line;
    logic [3:0]  r_cc, n_cc;
    logic        r_fht, n_fht;
    logic [23:0] r_tag, n_tag;
    t_coord      r_cur, n_cur;
    logic [2:0]  r_icnt, n_icnt;
    logic [2:0]  r_fcnt, n_fcnt;
    t_coord      r_lat, n_lat;
    t_coord      r_lon, n_lon;
    logic        r_lat_neg, n_lat_neg;
    logic        r_lon_neg, n_lon_neg;
    logic        r_bad, n_bad;

    logic        accept;
    logic        is_eol;
    logic        is_digit;
    logic [3:0]  digit;
    logic        dir_neg;
    logic [3:0]  fields;
    logic [16:0] frac_add;

    assign o_ready  = !i_full;
    assign accept   = i_valid && o_ready;
    assign is_eol   = (i_rx_byte == CH_CR) || (i_rx_byte == CH_LF);
    assign is_digit = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign digit    = i_rx_byte[3:0];
    assign dir_neg  = (i_rx_byte == CH_SOUTH) || (i_rx_byte == CH_WEST);
    assign frac_add = 17'({13'd0, digit} * frac_weight(r_fcnt));

    // request for the line being closed; an open coordinate field closes here
    assign fields = r_cc + (((r_cc < 4'(MAX_FIELDS)) && r_fht) ? 4'd1 : 4'd0);
    always_comb begin
        o_job.ok      = (r_tag == TAG_RMC) && (fields >= 4'(MIN_FIELDS)) && !r_bad;
        o_job.lat_neg = r_lat_neg;
        o_job.lon_neg = r_lon_neg;
        o_job.lat     = (r_cc == FIELD_LAT) ? r_cur : r_lat;
        o_job.lon     = (r_cc == FIELD_LON) ? r_cur : r_lon;
    end
    assign o_push = accept && is_eol && r_line;

    // next-state logic of the field parser
    always_comb begin
        n_line    = r_line;
        n_cc      = r_cc;
        n_fht     = r_fht;
        n_tag     = r_tag;
        n_cur     = r_cur;
        n_icnt    = r_icnt;
        n_fcnt    = r_fcnt;
        n_lat     = r_lat;
        n_lon     = r_lon;
        n_lat_neg = r_lat_neg;
        n_lon_neg = r_lon_neg;
        n_bad     = r_bad;
        if (accept) begin
            if (is_eol) begin
                // line end clears everything
                n_line    = 1'b0;
                n_cc      = 4'd0;
                n_fht     = 1'b0;
                n_tag     = 24'd0;
                n_cur     = '0;
                n_icnt    = 3'd0;
                n_fcnt    = 3'd0;
                n_lat     = '0;
                n_lon     = '0;
                n_lat_neg = 1'b0;
                n_lon_neg = 1'b0;
                n_bad     = 1'b0;
            end else begin
                n_line = 1'b1;
                if (r_cc < 4'(MAX_FIELDS)) begin
                    if (i_rx_byte == CH_COMMA) begin
                        // close field, move to the next one
                        if (r_cc == FIELD_LAT) begin
                            n_lat = r_cur;
                        end
                        if (r_cc == FIELD_LON) begin
                            n_lon = r_cur;
                        end
                        n_cc   = r_cc + 4'd1;
                        n_fht  = 1'b0;
                        n_cur  = '0;
                        n_icnt = 3'd0;
                        n_fcnt = 3'd0;
                    end else begin
                        n_fht = 1'b1;
                        case (r_cc) inside
                            FIELD_TAG: begin
                                n_tag = {r_tag[15:0], i_rx_byte};
                            end
                            FIELD_LAT, FIELD_LON: begin
                                if (is_digit) begin
                                    if (!r_cur.pt) begin
                                        if (r_icnt < 3'(INT_DIGITS)) begin
                                            // degrees take the digit leaving the minutes
                                            n_cur.deg  = 10'(r_cur.deg * 10'd10)
                                                       + {6'd0, r_cur.mm_t};
                                            n_cur.mm_t = r_cur.mm_o;
                                            n_cur.mm_o = digit;
                                            n_icnt     = r_icnt + 3'd1;
                                        end else begin
                                            n_bad = 1'b1;
                                        end
                                    end else if (r_fcnt < 3'(FRAC_DIGITS)) begin
                                        n_cur.frac = r_cur.frac + frac_add;
                                        n_fcnt     = r_fcnt + 3'd1;
                                    end
                                end else if (i_rx_byte == CH_POINT) begin
                                    if (r_cur.pt) begin
                                        n_bad = 1'b1;
                                    end else begin
                                        n_cur.pt = 1'b1;
                                    end
                                end else begin
                                    n_bad = 1'b1;
                                end
                            end
                            FIELD_LAT_DIR: begin
                                if (!r_fht) begin
                                    n_lat_neg = dir_neg;
                                end
                            end
                            FIELD_LON_DIR: begin
                                if (!r_fht) begin
                                    n_lon_neg = dir_neg;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line    <= 1'b0;
            r_cc      <= 4'd0;
            r_fht     <= 1'b0;
            r_tag     <= 24'd0;
            r_cur     <= '0;
            r_icnt    <= 3'd0;
            r_fcnt    <= 3'd0;
            r_lat     <= '0;
            r_lon     <= '0;
            r_lat_neg <= 1'b0;
            r_lon_neg <= 1'b0;
            r_bad     <= 1'b0;
        end else begin
            r_line    <= n_line;
            r_cc      <= n_cc;
            r_fht     <= n_fht;
            r_tag     <= n_tag;
            r_cur     <= n_cur;
            r_icnt    <= n_icnt;
            r_fcnt    <= n_fcnt;
            r_lat     <= n_lat;
            r_lon     <= n_lon;
            r_lat_neg <= n_lat_neg;
            r_lon_neg <= n_lon_neg;
            r_bad     <= n_bad;
        end
    end

endmodule

FILE: hdl/nrp_fifo.sv
// short request queue between the front and back ends
// depends on nrp_pkg for the request type and depth
module nrp_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nrp_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output nrp_pkg::t_job o_job
);
    import nrp_pkg::*;

    t_job                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, n_wr;
    logic [FIFO_AW-1:0]   r_rd, n_rd;
    logic [FIFO_AW:0]     r_count, n_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    // pointer and fill count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // queue never overruns or underruns
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("request pushed into full queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("request popped from empty queue");

    // fill count tracks the pointers
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == (FIFO_AW+1)'(FIFO_DEPTH)) || (r_count[FIFO_AW-1:0] == (r_wr - r_rd)))
        else $error("queue fill count disagrees with pointers");

endmodule

FILE: hdl/nrp_back.sv
// back end: converts degrees and minutes to signed microdegrees
// depends on nrp_pkg; pops requests from the queue, drives the result port
module nrp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    output logic               o_pop,
    input  nrp_pkg::t_job      i_job,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_valid_res,
    output logic signed [30:0] o_lat_microdeg,
    output logic signed [30:0] o_lon_microdeg
);
    import nrp_pkg::*;

    localparam int unsigned LANES = 2;

    logic        adv;
    t_coord      coord [LANES];
    logic        neg   [LANES];

    // stage 1: minutes scaled to 1e-5
    logic        r_s1_v;
    logic        r_s1_ok;
    logic        r_s1_neg [LANES];
    logic        r_s1_pt  [LANES];
    logic [9:0]  r_s1_deg [LANES];
    logic [23:0] r_s1_x   [LANES];
    // stage 2: reciprocal product and degree product
    logic        r_s2_v;
    logic        r_s2_ok;
    logic        r_s2_neg  [LANES];
    logic        r_s2_pt   [LANES];
    logic [22:0] r_s2_y    [LANES];
    logic [21:0] r_s2_q0   [LANES];
    logic [29:0] r_s2_degm [LANES];
    // stage 3: corrected quotient and magnitude
    logic        r_s3_v;
    logic        r_s3_ok;
    logic        r_s3_neg [LANES];
    logic [29:0] r_s3_mag [LANES];
    // output register
    logic        r_out_v;
    logic        r_out_ok;
    logic [30:0] r_out_val [LANES];

    assign adv      = !r_out_v || i_ready;
    assign o_pop    = adv && !i_empty;
    assign coord[0] = i_job.lat;
    assign coord[1] = i_job.lon;
    assign neg[0]   = i_job.lat_neg;
    assign neg[1]   = i_job.lon_neg;

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_s1_v  <= o_pop;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_out_v <= r_s3_v;
        end
    end

    // datapath, both lanes side by side
    always_ff @(posedge i_clk) begin
        logic [6:0]  mm;
        logic [43:0] prod;
        logic [22:0] rem;
        logic [21:0] q;
        logic [30:0] mag31;
        if (adv) begin
            r_s1_ok  <= i_job.ok;
            r_s2_ok  <= r_s1_ok;
            r_s3_ok  <= r_s2_ok;
            r_out_ok <= r_s3_ok;
            for (int i = 0; i < LANES; i++) begin
                // x = minutes * 1e5 + fraction
                mm           = 7'(coord[i].mm_t * 7'd10) + {3'd0, coord[i].mm_o};
                r_s1_neg[i]  <= neg[i];
                r_s1_pt[i]   <= coord[i].pt;
                r_s1_deg[i]  <= coord[i].deg;
                r_s1_x[i]    <= 24'({17'd0, mm} * {7'd0, MM_SCALE}) + {7'd0, coord[i].frac};
                // x / 6 = (x >> 1) / 3, estimate from the reciprocal
                prod         = {21'd0, r_s1_x[i][23:1]} * {23'd0, RECIP_3};
                r_s2_neg[i]  <= r_s1_neg[i];
                r_s2_pt[i]   <= r_s1_pt[i];
                r_s2_y[i]    <= r_s1_x[i][23:1];
                r_s2_q0[i]   <= prod[RECIP_SHIFT +: 22];
                r_s2_degm[i] <= 30'({20'd0, r_s1_deg[i]} * {10'd0, DEG_SCALE});
                // estimate is at most one short
                rem          = r_s2_y[i] - 23'({1'b0, r_s2_q0[i]} * 23'd3);
                q            = r_s2_q0[i] + ((rem >= 23'd3) ? 22'd1 : 22'd0);
                r_s3_neg[i]  <= r_s2_neg[i];
                r_s3_mag[i]  <= r_s2_pt[i] ? (r_s2_degm[i] + {8'd0, q}) : 30'd0;
                // sign and validity
                mag31        = {1'b0, r_s3_mag[i]};
                if (!r_s3_ok) begin
                    r_out_val[i] <= 31'd0;
                end else if (r_s3_neg[i]) begin
                    r_out_val[i] <= 31'd0 - mag31;
                end else begin
                    r_out_val[i] <= mag31;
                end
            end
        end
    end

    assign o_valid        = r_out_v;
    assign o_valid_res    = r_out_ok;
    assign o_lat_microdeg = r_out_val[0];
    assign o_lon_microdeg = r_out_val[1];

    // a held result stays put while the sink stalls
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_ready) |=> (r_out_v && $stable(r_out_val[0]) && $stable(r_out_val[1])))
        else $error("stalled result changed");

    // an invalid line never carries a coordinate
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_ok) |-> (r_out_val[0] == 31'd0 && r_out_val[1] == 31'd0))
        else $error("invalid line with non-zero coordinate");

endmodule

FILE: hdl/nmea_rmc_position_parser.sv
// rmc position parser: one character per cycle in while ready is high, one result per line out
// a result passes the line queue, the back-end stages and the output register after CR or LF
// throughput: one character per cycle; ready falls only while the 4-entry
// line queue is full, i.e. when the result sink stalls for several lines
// reset: synchronous active-low i_rst_n clears parser state, queue and pipeline
// depends on nrp_pkg, nrp_front, nrp_fifo and nrp_back
module nmea_rmc_position_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_valid_res,
    output logic signed [30:0] o_lat_microdeg,
    output logic signed [30:0] o_lon_microdeg
);
    import nrp_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job job_in;
    t_job job_out;

    // character parser
    nrp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_full    (full),
        .o_push    (push),
        .o_job     (job_in)
    );

    // line request queue
    nrp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (job_out)
    );

    // coordinate conversion
    nrp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .o_pop          (pop),
        .i_job          (job_out),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_valid_res    (o_valid_res),
        .o_lat_microdeg (o_lat_microdeg),
        .o_lon_microdeg (o_lon_microdeg)
    );

endmodule
